>>> sv/skglim_pkg.sv
`timescale 1ns / 1ps

package skglim_pkg;

	// product of sample magnitude and gain
	localparam int PROD_W = 33;
	// magnitude of a sample, wide enough for 32768
	localparam int MAG_W = 17;

	// limiter curve constants in Q2.16
	localparam logic [15:0] KNEE_Q16 = 16'd55706;
	localparam logic [13:0] HEAD_Q16 = 14'd9830;
	localparam logic [16:0] ONE_Q16 = 17'd65536;
	localparam logic [31:0] ROUND_Q16 = 32'd32768;

	// saturation limits of the Q0.15 magnitude
	localparam logic [MAG_W-1:0] Q15_POS_MAX = 17'd32767;
	localparam logic [MAG_W-1:0] Q15_NEG_MAX = 17'd32768;

	// gain register after reset, about +12 dB in Q4.12
	localparam logic [15:0] GAIN_RESET = 16'd16306;

	// word between front and back
	typedef struct packed {
		logic [PROD_W-1:0] prod;
		logic              neg;
		logic              last;
	} mid_word_t;

	// result word
	typedef struct packed {
		logic [15:0] sample;
		logic        last;
	} out_word_t;

endpackage

>>> sv/skglim_fifo.sv
`timescale 1ns / 1ps

module skglim_fifo #(
	parameter int WIDTH      = 1,
	parameter int DEPTH_BITS = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             rd,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int DEPTH = 1 << DEPTH_BITS;

	logic [WIDTH-1:0]    mem_q [DEPTH];
	logic [DEPTH_BITS-1:0] wr_ptr_q;
	logic [DEPTH_BITS-1:0] rd_ptr_q;
	logic [DEPTH_BITS:0]   count_q;

	// status flags
	assign full  = (count_q == (DEPTH_BITS + 1)'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr && !rd) begin
				count_q <= count_q + 1'b1;
			end else if (rd && !wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	a_no_write_when_full : assert property (@(posedge clk) disable iff (!arst_n)
		wr |-> !full)
		else $error("fifo written while full");

	a_no_read_when_empty : assert property (@(posedge clk) disable iff (!arst_n)
		rd |-> !empty)
		else $error("fifo read while empty");

	a_write_shows : assert property (@(posedge clk) disable iff (!arst_n)
		(wr && !rd) |=> !empty)
		else $error("fifo still empty after a write");

endmodule

>>> sv/skglim_front.sv
`timescale 1ns / 1ps

module skglim_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  logic signed [15:0]     in_sample,
	input  logic                   last_in,
	input  logic [15:0]            gain,
	output logic                   mid_wr,
	output skglim_pkg::mid_word_t  mid_word,
	input  logic                   mid_full
);

	logic                           neg_in;
	logic [skglim_pkg::MAG_W-1:0]   amag_in;
	logic                           accept;

	logic                           valid_s1;
	logic                           neg_s1;
	logic                           last_s1;
	logic [skglim_pkg::MAG_W-1:0]   amag_s1;

	// sign split and magnitude of the incoming word
	always_comb begin
		neg_in = in_sample[15];
		if (neg_in) begin
			amag_in = 17'h10000 - {1'b0, in_sample};
		end else begin
			amag_in = {1'b0, in_sample};
		end
	end

	// the input stage holds only while the queue is full
	assign full   = valid_s1 && mid_full;
	assign accept = push && !full;
	assign mid_wr = valid_s1 && !mid_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!full) begin
			valid_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			neg_s1  <= neg_in;
			last_s1 <= last_in;
			amag_s1 <= amag_in;
		end
	end

	// gain multiply into the queue word
	always_comb begin
		mid_word.prod = skglim_pkg::PROD_W'(amag_s1) * skglim_pkg::PROD_W'(gain);
		mid_word.neg  = neg_s1;
		mid_word.last = last_s1;
	end

endmodule

>>> sv/skglim_back.sv
`timescale 1ns / 1ps

module skglim_back #(
	parameter int LUT_ADDR_BITS  = 8,
	parameter int GAIN_FRAC_BITS = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  skglim_pkg::mid_word_t mid_word,
	input  logic                  mid_empty,
	output logic                  mid_pop,
	output skglim_pkg::out_word_t out_word,
	output logic                  out_wr,
	input  logic                  out_full
);

	localparam int LUT_SIZE  = 1 << LUT_ADDR_BITS;
	localparam int EXC_SHIFT = 17 - LUT_ADDR_BITS;
	localparam int M16_W     = skglim_pkg::PROD_W + 1 - GAIN_FRAC_BITS;
	localparam int SUM_W     = skglim_pkg::PROD_W + 1;
	localparam int IW        = 18 + EXC_SHIFT;
	localparam int MW        = skglim_pkg::MAG_W;
	localparam logic [63:0] N3  = 64'(3 * LUT_SIZE);
	localparam logic [63:0] X30 = ((64'd40 << 30) + N3 / 2) / N3;
	localparam logic [LUT_ADDR_BITS:0] LAST_IDX = {1'b1, {LUT_ADDR_BITS{1'b0}}};
	localparam logic [IW-1:0] HALF_STEP = IW'(1) << (EXC_SHIFT - 1);

	typedef logic [16:0] rom_t [LUT_SIZE + 1];

	// exp(-x/0.15) over excess [0, 2.0) in Q2.16, as powers of one step ratio
	function automatic rom_t build_rom();
		logic [63:0] term;
		logic [63:0] pos;
		logic [63:0] neg_sum;
		logic [63:0] ratio;
		logic [63:0] t30;
		rom_t        rom;
		term    = 64'd1 << 30;
		pos     = term;
		neg_sum = '0;
		t30     = 64'd1 << 30;
		// series of exp(-x) for one step, in Q30
		for (int k = 1; k <= 24; k++) begin
			term = ((term * X30) >> 30) / 64'(k);
			if (k[0]) begin
				neg_sum = neg_sum + term;
			end else begin
				pos = pos + term;
			end
		end
		ratio  = pos - neg_sum;
		rom[0] = skglim_pkg::ONE_Q16;
		for (int i = 1; i <= LUT_SIZE; i++) begin
			t30    = (t30 * ratio + (64'd1 << 29)) >> 30;
			rom[i] = 17'((t30 + (64'd1 << 13)) >> 14);
		end
		return rom;
	endfunction

	localparam rom_t EXP_ROM = build_rom();

	logic adv;

	// classify against the knee
	logic [M16_W-1:0] mag16;
	logic [M16_W-1:0] exc;
	logic [SUM_W-1:0] round_sum;
	logic [M16_W-1:0] lin_full;
	logic [MW-1:0]    lin_cap;

	logic                      v_s2, neg_s2, last_s2, above_s2, sat_s2;
	logic [LUT_ADDR_BITS-1:0]  idx_s2;
	logic [EXC_SHIFT-1:0]      frac_s2;
	logic [MW-1:0]             lin_s2;

	logic [LUT_ADDR_BITS:0]    lo_idx;
	logic [LUT_ADDR_BITS:0]    hi_idx;
	logic [16:0]               rom_lo;
	logic [16:0]               rom_hi;

	logic                      v_s3, neg_s3, last_s3, above_s3;
	logic [16:0]               base_s3;
	logic [16:0]               diff_s3;
	logic [EXC_SHIFT-1:0]      frac_s3;
	logic [MW-1:0]             lin_s3;

	logic [IW-1:0]             interp;

	logic                      v_s4, neg_s4, last_s4, above_s4;
	logic [16:0]               exp_s4;
	logic [MW-1:0]             lin_s4;

	logic [31:0]               head_prod;
	logic [16:0]               lim_r;
	logic [MW-1:0]             mag_next;

	logic                      v_s5, neg_s5, last_s5;
	logic [MW-1:0]             mag_s5;

	logic [MW-1:0]             cap_neg;
	logic [15:0]               cap_pos;

	// the whole pipe moves unless the last stage is blocked
	assign adv     = !(v_s5 && out_full);
	assign mid_pop = adv && !mid_empty;
	assign out_wr  = v_s5 && !out_full;

	always_comb begin
		mag16     = M16_W'(mid_word.prod >> (GAIN_FRAC_BITS - 1));
		exc       = mag16 - M16_W'(skglim_pkg::KNEE_Q16);
		round_sum = {1'b0, mid_word.prod} + (SUM_W'(1) << (GAIN_FRAC_BITS - 1));
		lin_full  = M16_W'(round_sum >> GAIN_FRAC_BITS);
		if (lin_full > M16_W'(skglim_pkg::Q15_NEG_MAX)) begin
			lin_cap = skglim_pkg::Q15_NEG_MAX;
		end else begin
			lin_cap = lin_full[MW-1:0];
		end
	end

	// table address, clamped to the last entry beyond the table
	always_comb begin
		if (sat_s2) begin
			lo_idx = LAST_IDX;
			hi_idx = LAST_IDX;
		end else begin
			lo_idx = {1'b0, idx_s2};
			hi_idx = {1'b0, idx_s2} + (LUT_ADDR_BITS + 1)'(1);
		end
		rom_lo = EXP_ROM[lo_idx];
		rom_hi = EXP_ROM[hi_idx];
	end

	// linear interpolation, table is decreasing so the slope is a subtraction
	assign interp = (IW'(base_s3) << EXC_SHIFT) - IW'(diff_s3) * IW'(frac_s3) + HALF_STEP;

	// soft curve above the knee, rounded to Q0.15
	always_comb begin
		head_prod = 32'(skglim_pkg::HEAD_Q16) * 32'(skglim_pkg::ONE_Q16 - exp_s4)
			+ skglim_pkg::ROUND_Q16;
		lim_r     = 17'(skglim_pkg::KNEE_Q16) + 17'd1 + 17'(head_prod >> 16);
		if (above_s4) begin
			mag_next = lim_r >> 1;
		end else begin
			mag_next = lin_s4;
		end
	end

	// sign dependent saturation and negation
	always_comb begin
		if (mag_s5 > skglim_pkg::Q15_NEG_MAX) begin
			cap_neg = skglim_pkg::Q15_NEG_MAX;
		end else begin
			cap_neg = mag_s5;
		end
		if (mag_s5 > skglim_pkg::Q15_POS_MAX) begin
			cap_pos = 16'(skglim_pkg::Q15_POS_MAX);
		end else begin
			cap_pos = mag_s5[15:0];
		end
		if (neg_s5) begin
			out_word.sample = 16'(17'd0 - cap_neg);
		end else begin
			out_word.sample = cap_pos;
		end
		out_word.last = last_s5;
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s2 <= mid_pop;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s2   <= mid_word.neg;
			last_s2  <= mid_word.last;
			above_s2 <= (mag16 > M16_W'(skglim_pkg::KNEE_Q16));
			sat_s2   <= |exc[M16_W-1:17];
			idx_s2   <= exc[16:EXC_SHIFT];
			frac_s2  <= exc[EXC_SHIFT-1:0];
			lin_s2   <= lin_cap;

			neg_s3   <= neg_s2;
			last_s3  <= last_s2;
			above_s3 <= above_s2;
			lin_s3   <= lin_s2;
			base_s3  <= rom_lo;
			diff_s3  <= rom_lo - rom_hi;
			frac_s3  <= frac_s2;

			neg_s4   <= neg_s3;
			last_s4  <= last_s3;
			above_s4 <= above_s3;
			lin_s4   <= lin_s3;
			exp_s4   <= 17'(interp >> EXC_SHIFT);

			neg_s5   <= neg_s4;
			last_s5  <= last_s4;
			mag_s5   <= mag_next;
		end
	end

	a_hold_when_blocked : assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && out_full) |=> (v_s5 && $stable(mag_s5) && $stable(neg_s5)))
		else $error("blocked result changed");

	a_pop_has_word : assert property (@(posedge clk) disable iff (!arst_n)
		mid_pop |-> !mid_empty)
		else $error("queue popped while empty");

	a_soft_in_range : assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 |-> (mag_s5 <= skglim_pkg::Q15_NEG_MAX))
		else $error("magnitude beyond full scale");

endmodule

>>> sv/soft_knee_gain_limiter_core.sv
`timescale 1ns / 1ps

// channel   direction  handshake          payload
// input     in         push / full        in_sample, last_in
// result    out        pop / empty        out_sample, last_out
// config    in         gain_we            gain_multiplier
//
// One word is accepted per clock while full is low; a result passes the input
// stage, the front queue, four back stages (classify, table read, interpolation
// multiply, curve multiply) and the result queue before it shows on the result ports.
// Reset clears all queues and valids and loads the gain with about +12 dB.
// A blocked result queue stalls the back stages; the front queue absorbs the
// difference so the input keeps flowing until both queues fill.

module soft_knee_gain_limiter_core #(
	parameter int LUT_ADDR_BITS  = 8,
	parameter int GAIN_FRAC_BITS = 12
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic signed [15:0] in_sample,
	input  logic               last_in,
	output logic               empty,
	input  logic               pop,
	output logic signed [15:0] out_sample,
	output logic               last_out,
	input  logic               gain_we,
	input  logic [15:0]        gain_multiplier
);

	localparam int QUEUE_BITS = 2;

	logic [15:0]           gain_q;
	logic                  mid_wr;
	logic                  mid_full;
	logic                  mid_pop;
	logic                  mid_empty;
	skglim_pkg::mid_word_t mid_in;
	skglim_pkg::mid_word_t mid_out;
	skglim_pkg::out_word_t res_in;
	skglim_pkg::out_word_t res_out;
	logic                  res_wr;
	logic                  res_full;
	logic                  res_empty;
	logic                  res_rd;

	// gain register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= skglim_pkg::GAIN_RESET;
		end else if (gain_we) begin
			gain_q <= gain_multiplier;
		end
	end

	skglim_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.in_sample (in_sample),
		.last_in   (last_in),
		.gain      (gain_q),
		.mid_wr    (mid_wr),
		.mid_word  (mid_in),
		.mid_full  (mid_full)
	);

	skglim_fifo #(
		.WIDTH      ($bits(skglim_pkg::mid_word_t)),
		.DEPTH_BITS (QUEUE_BITS)
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (mid_wr),
		.wdata  (mid_in),
		.full   (mid_full),
		.rd     (mid_pop),
		.rdata  (mid_out),
		.empty  (mid_empty)
	);

	skglim_back #(
		.LUT_ADDR_BITS  (LUT_ADDR_BITS),
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mid_word  (mid_out),
		.mid_empty (mid_empty),
		.mid_pop   (mid_pop),
		.out_word  (res_in),
		.out_wr    (res_wr),
		.out_full  (res_full)
	);

	skglim_fifo #(
		.WIDTH      ($bits(skglim_pkg::out_word_t)),
		.DEPTH_BITS (QUEUE_BITS)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (res_wr),
		.wdata  (res_in),
		.full   (res_full),
		.rd     (res_rd),
		.rdata  (res_out),
		.empty  (res_empty)
	);

	// result side
	assign res_rd     = pop && !res_empty;
	assign empty      = res_empty;
	assign out_sample = $signed(res_out.sample);
	assign last_out   = res_out.last;

endmodule
